FILE: rtl/periodic_lattice_neighbor_unit_defines.svh
// Assertion macros for the periodic lattice neighbour unit.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef PERIODIC_LATTICE_NEIGHBOR_UNIT_DEFINES_SVH
`define PERIODIC_LATTICE_NEIGHBOR_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PLNU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define PLNU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PLNU_ASSERT_IMP(lbl, ante, cons, msg)
`define PLNU_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/plnu_pkg.sv
// Shared constants and types for the periodic lattice neighbour unit.
// No dependencies.
`timescale 1ns / 1ps
package plnu_pkg;
  localparam int SITE_W       = 32;
  localparam int DIR_W        = 3;
  localparam int CFG_W        = 9;
  localparam int CFG_IDX_W    = 8;
  localparam int NUM_REGS     = 4;
  localparam int EXTENT_RESET = 16;

  typedef struct packed {
    logic full;  // skid register holds a transaction
    logic busy;  // output register holds a transaction
  } plnu_skid_stat_t;
endpackage

FILE: rtl/plnu_in_if.sv
// Input channel: site index and direction with valid/ready.
// Depends on plnu_pkg.
`timescale 1ns / 1ps
interface plnu_in_if import plnu_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [SITE_W-1:0]        site_index;
  logic signed [DIR_W-1:0]  direction;
  modport source (output valid, site_index, direction, input ready);
  modport sink   (input valid, site_index, direction, output ready);
endinterface

FILE: rtl/plnu_out_if.sv
// Output channel: neighbour index and bad-direction flag with valid/ready.
// Depends on plnu_pkg.
`timescale 1ns / 1ps
interface plnu_out_if import plnu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SITE_W-1:0] neighbor_index;
  logic              bad_direction;
  modport source (output valid, neighbor_index, bad_direction, input ready);
  modport sink   (input valid, neighbor_index, bad_direction, output ready);
endinterface

FILE: rtl/plnu_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Depends on plnu_pkg.
`timescale 1ns / 1ps
module plnu_div import plnu_pkg::*; #(
  parameter int EXTENT_BITS = 8,
  parameter int SIDE_W      = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [SITE_W-1:0]      word_i,
  input  logic [SIDE_W-1:0]      side_i,
  input  logic [EXTENT_BITS:0]   divisor_i,
  output logic                   valid_o,
  output logic [SITE_W-1:0]      quot_o,
  output logic [EXTENT_BITS-1:0] rem_o,
  output logic [SIDE_W-1:0]      side_o
);
  localparam int EB = EXTENT_BITS;

  logic [SITE_W-1:0] v_q;
  logic [SITE_W-1:0] word_q [SITE_W];
  logic [EB-1:0]     rem_q  [SITE_W];
  logic [SIDE_W-1:0] side_q [SITE_W];

  for (genvar s = 0; s < SITE_W; s++) begin : g_stage
    logic              v_in;
    logic [SITE_W-1:0] w_in;
    logic [EB-1:0]     r_in;
    logic [SIDE_W-1:0] sd_in;
    logic [EB:0]       trial;
    logic              ge;
    logic [EB-1:0]     rem_d;
    logic [SITE_W-1:0] word_d;

    if (s == 0) begin : g_first
      assign v_in  = valid_i;
      assign w_in  = word_i;
      assign r_in  = '0;
      assign sd_in = side_i;
    end else begin : g_next
      assign v_in  = v_q[s-1];
      assign w_in  = word_q[s-1];
      assign r_in  = rem_q[s-1];
      assign sd_in = side_q[s-1];
    end

    // Shift in the next dividend bit, subtract when it fits.
    always_comb begin
      trial  = {r_in, w_in[SITE_W-1]};
      ge     = (trial >= divisor_i);
      rem_d  = ge ? EB'(trial - divisor_i) : EB'(trial);
      word_d = {w_in[SITE_W-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        word_q[s] <= word_d;
        rem_q[s]  <= rem_d;
        side_q[s] <= sd_in;
      end
    end
  end

  assign valid_o = v_q[SITE_W-1];
  assign quot_o  = word_q[SITE_W-1];
  assign rem_o   = rem_q[SITE_W-1];
  assign side_o  = side_q[SITE_W-1];
endmodule

FILE: rtl/plnu_recode.sv
// Step one coordinate with wrap, then re-encode through multiply-add stages.
// Depends on plnu_pkg.
`timescale 1ns / 1ps
module plnu_recode import plnu_pkg::*; #(
  parameter int NUM_AXES    = 4,
  parameter int EXTENT_BITS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic [SITE_W-1:0]                 site_i,
  input  logic signed [DIR_W-1:0]           dir_i,
  input  logic [NUM_AXES*EXTENT_BITS-1:0]   coord_i,
  input  logic [NUM_AXES*(EXTENT_BITS+1)-1:0] ext_i,
  output logic                              valid_o,
  output logic [SITE_W-1:0]                 nbr_o,
  output logic                              bad_o
);
  localparam int EB = EXTENT_BITS;
  localparam int N  = NUM_AXES;
  localparam int CW = N * EB;
  localparam int NM = N - 1;

  // Step stage
  logic          bad_d;
  logic [CW-1:0] c_d;

  always_comb begin
    int d;
    logic [EB:0]   e;
    logic [EB-1:0] c;
    logic [EB-1:0] e_m1;
    d     = int'(dir_i);
    bad_d = 1'b1;
    c_d   = coord_i;
    for (int k = 0; k < N; k++) begin
      e    = ext_i[k*(EB+1) +: EB+1];
      c    = coord_i[k*EB +: EB];
      e_m1 = EB'(e - 1'b1);
      if (d == k) begin
        bad_d          = 1'b0;
        c_d[k*EB +: EB] = (c == e_m1) ? '0 : EB'(c + 1'b1);
      end else if (d == -k - 1) begin
        bad_d          = 1'b0;
        c_d[k*EB +: EB] = (c == '0) ? e_m1 : EB'(c - 1'b1);
      end
    end
  end

  logic              va_q;
  logic              bada_q;
  logic [SITE_W-1:0] sitea_q;
  logic [CW-1:0]     ca_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bada_q  <= bad_d;
      sitea_q <= site_i;
      ca_q    <= c_d;
    end
  end

  // Horner stages, slowest axis first
  logic [NM-1:0]     vm_q;
  logic [NM-1:0]     badm_q;
  logic [SITE_W-1:0] sitem_q [NM];
  logic [SITE_W-1:0] acc_q   [NM];
  logic [CW-1:0]     cm_q    [NM];

  for (genvar j = 0; j < NM; j++) begin : g_mac
    localparam int K = N - 1 - j;
    logic              v_in;
    logic              bad_in;
    logic [SITE_W-1:0] site_in;
    logic [SITE_W-1:0] acc_in;
    logic [CW-1:0]     c_in;
    logic [SITE_W-1:0] acc_d;

    if (j == 0) begin : g_first
      assign v_in    = va_q;
      assign bad_in  = bada_q;
      assign site_in = sitea_q;
      assign c_in    = ca_q;
      assign acc_in  = SITE_W'(ca_q[(N-1)*EB +: EB]);
    end else begin : g_next
      assign v_in    = vm_q[j-1];
      assign bad_in  = badm_q[j-1];
      assign site_in = sitem_q[j-1];
      assign c_in    = cm_q[j-1];
      assign acc_in  = acc_q[j-1];
    end

    // Wraps modulo 2^32, which is all the output keeps.
    assign acc_d = SITE_W'(acc_in * SITE_W'(ext_i[(K-1)*(EB+1) +: EB+1]))
                 + SITE_W'(c_in[(K-1)*EB +: EB]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vm_q[j] <= 1'b0;
      end else if (en_i) begin
        vm_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        badm_q[j]  <= bad_in;
        sitem_q[j] <= site_in;
        cm_q[j]    <= c_in;
        acc_q[j]   <= acc_d;
      end
    end
  end

  // A bad direction passes the site through untouched.
  assign valid_o = vm_q[NM-1];
  assign bad_o   = badm_q[NM-1];
  assign nbr_o   = badm_q[NM-1] ? sitem_q[NM-1] : acc_q[NM-1];
endmodule

FILE: rtl/plnu_skid.sv
// Output register with a skid register behind it.
// Depends on plnu_pkg.
`timescale 1ns / 1ps
module plnu_skid import plnu_pkg::*; #(
  parameter int W = 33
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            up_valid_i,
  input  logic [W-1:0]    up_data_i,
  output logic            up_ready_o,
  output logic            dn_valid_o,
  input  logic            dn_ready_i,
  output logic [W-1:0]    dn_data_o,
  output plnu_skid_stat_t stat_o
);
  logic         out_v_q;
  logic         skid_v_q;
  logic [W-1:0] out_q;
  logic [W-1:0] skid_q;

  assign up_ready_o = !skid_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (dn_ready_i || !out_v_q) begin
      out_v_q  <= skid_v_q || up_valid_i;
      skid_v_q <= 1'b0;
    end else if (up_valid_i && !skid_v_q) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dn_ready_i || !out_v_q) begin
      out_q <= skid_v_q ? skid_q : up_data_i;
    end else if (up_valid_i && !skid_v_q) begin
      skid_q <= up_data_i;
    end
  end

  assign dn_valid_o  = out_v_q;
  assign dn_data_o   = out_q;
  assign stat_o.full = skid_v_q;
  assign stat_o.busy = out_v_q;
endmodule

FILE: rtl/periodic_lattice_neighbor_unit.sv
// Top level of the periodic lattice neighbour unit.
// Depends on plnu_pkg, plnu_in_if, plnu_out_if, plnu_div, plnu_recode, plnu_skid.
`timescale 1ns / 1ps
// Neighbour index on a periodic NUM_AXES-dimensional lattice. Each input
// transaction carries a lexicographic site index (axis 0 fastest) and a signed
// direction: 0..NUM_AXES-1 steps forward on that axis, -1..-NUM_AXES steps
// backward on axis -direction-1, with periodic wrap; the slowest coordinate is
// reduced modulo its extent too, so indices beyond the volume wrap. Any other
// direction returns the site unchanged with bad_direction set. One transaction
// is taken per clock cycle while the skid register is not full. The pipeline
// follows the coordinate split: one 32-stage restoring divider per axis, one
// quotient bit per stage, then one step stage and NUM_AXES-1 multiply-add
// stages ahead of the output register. Extents are written through
// cfg_we_i/cfg_idx_i/cfg_wdata_i (index 0 is axis 0); a zero extent acts as 1,
// an extent above 2^EXTENT_BITS acts as 2^EXTENT_BITS, and writes to an index
// with no register are dropped. Write them only while the unit is idle. A
// stalled output holds the pipeline once the skid register fills; nothing is
// lost or repeated.
`include "periodic_lattice_neighbor_unit_defines.svh"
module periodic_lattice_neighbor_unit import plnu_pkg::*; #(
  parameter int NUM_AXES    = 4,
  parameter int EXTENT_BITS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  plnu_in_if.sink              in_ch,
  plnu_out_if.source           out_ch
);
  localparam int EB      = EXTENT_BITS;
  localparam int N       = NUM_AXES;
  localparam int CW      = N * EB;
  localparam int SIDE_W  = SITE_W + DIR_W + CW;
  localparam int EXT_MAX = 1 << EB;
  localparam int OUT_W   = SITE_W + 1;

  // Clamp a raw extent into 1..2^EXTENT_BITS when it is written.
  function automatic logic [EB:0] eff_extent(input logic [CFG_W-1:0] raw);
    logic [EB:0] e;
    if (raw == '0) begin
      e = (EB+1)'(1);
    end else if (int'(raw) > EXT_MAX) begin
      e = (EB+1)'(EXT_MAX);
    end else begin
      e = (EB+1)'(raw);
    end
    return e;
  endfunction

  logic [EB:0]             ext_q [N];
  logic [N*(EB+1)-1:0]     ext_flat;

  for (genvar k = 0; k < N; k++) begin : g_ext
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ext_q[k] <= eff_extent(CFG_W'(EXTENT_RESET));
      end else if (cfg_we_i && (cfg_idx_i == CFG_IDX_W'(k)) && (k < NUM_REGS)) begin
        ext_q[k] <= eff_extent(cfg_wdata_i);
      end
    end
    assign ext_flat[k*(EB+1) +: EB+1] = ext_q[k];
  end

  // Whole pipeline advances together; hold it only when the skid is full.
  logic            en;
  logic            skid_ready;
  plnu_skid_stat_t skid_stat;

  assign en          = skid_ready;
  assign in_ch.ready = en;

  // Divider chain: quotient of axis k feeds axis k+1, remainder is coord k.
  logic              valid_w [N+1];
  logic [SITE_W-1:0] word_w  [N+1];
  logic [SIDE_W-1:0] side_w  [N+1];

  assign valid_w[0] = in_ch.valid;
  assign word_w[0]  = in_ch.site_index;
  assign side_w[0]  = {in_ch.site_index, in_ch.direction, {CW{1'b0}}};

  for (genvar k = 0; k < N; k++) begin : g_axis
    logic [EB-1:0]     rem;
    logic [SIDE_W-1:0] side_mid;

    plnu_div #(
      .EXTENT_BITS (EB),
      .SIDE_W      (SIDE_W)
    ) u_div (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .valid_i   (valid_w[k]),
      .word_i    (word_w[k]),
      .side_i    (side_w[k]),
      .divisor_i (ext_q[k]),
      .valid_o   (valid_w[k+1]),
      .quot_o    (word_w[k+1]),
      .rem_o     (rem),
      .side_o    (side_mid)
    );

    // Drop the remainder into this axis' coordinate slot.
    always_comb begin
      side_w[k+1]                = side_mid;
      side_w[k+1][k*EB +: EB]    = rem;
    end
  end

  logic              rc_valid;
  logic [SITE_W-1:0] rc_nbr;
  logic              rc_bad;

  plnu_recode #(
    .NUM_AXES    (N),
    .EXTENT_BITS (EB)
  ) u_recode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (valid_w[N]),
    .site_i  (side_w[N][SIDE_W-1 -: SITE_W]),
    .dir_i   (side_w[N][CW +: DIR_W]),
    .coord_i (side_w[N][CW-1:0]),
    .ext_i   (ext_flat),
    .valid_o (rc_valid),
    .nbr_o   (rc_nbr),
    .bad_o   (rc_bad)
  );

  logic [OUT_W-1:0] out_data;

  plnu_skid #(
    .W (OUT_W)
  ) u_skid (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .up_valid_i (rc_valid),
    .up_data_i  ({rc_nbr, rc_bad}),
    .up_ready_o (skid_ready),
    .dn_valid_o (out_ch.valid),
    .dn_ready_i (out_ch.ready),
    .dn_data_o  (out_data),
    .stat_o     (skid_stat)
  );

  assign out_ch.neighbor_index = out_data[OUT_W-1:1];
  assign out_ch.bad_direction  = out_data[0];

  // Assertions
  `PLNU_ASSERT_IMP(a_skid_behind_out, skid_stat.full, skid_stat.busy && !in_ch.ready, "skid full without output held")
  `PLNU_ASSERT_NXT(a_skid_drains, skid_stat.full && out_ch.ready, !skid_stat.full && out_ch.valid, "skid did not drain")
  for (genvar k = 0; k < N; k++) begin : g_chk
    `PLNU_ASSERT_IMP(a_ext_range, 1'b1, ext_q[k] != '0 && int'(ext_q[k]) <= EXT_MAX, "extent out of range")
  end
endmodule

FILE: test/tb_periodic_lattice_neighbor_unit.sv
// Self-checking testbench for periodic_lattice_neighbor_unit.
// Needs plnu_pkg, plnu_in_if, plnu_out_if and the unit's RTL.
`timescale 1ns / 1ps
module tb_periodic_lattice_neighbor_unit;
  import plnu_pkg::*;

  // Register indexes of the extent registers
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_X = 0;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_Y = 1;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_Z = 2;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_T = 3;
  localparam logic [CFG_IDX_W-1:0] REG_NONE     = 200;

  // Pipeline depth of the unit; DRAIN_WAIT adds a margin to it
  localparam int PIPE_DEPTH   = 4 * 32 + 4 + 1;
  localparam int DRAIN_WAIT   = PIPE_DEPTH + 20;
  localparam int HOLD_OFF_LEN = 3 * PIPE_DEPTH;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic [SITE_W-1:0] neighbor;
    logic              bad;
  } neighbor_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;

  plnu_in_if  in_ch ();
  plnu_out_if out_ch ();

  periodic_lattice_neighbor_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_ch       (in_ch.sink),
    .out_ch      (out_ch.source)
  );

  // Predictor's copy of the extent registers (raw 9-bit values)
  logic [CFG_W-1:0] extent_raw [4];
  neighbor_res_t    expected_neighbors [$];
  int  mismatch_count = 0;
  int  cycle_count = 0;
  int  hold_off_request = 0;  // bumped by the test sequence to ask for a long stall
  int  hold_off_granted = 0;  // requests already taken up by the receiver
  int  hold_off_cycles = 0;   // long receiver stall, counted down by the receiver
  bit  random_stalls = 1'b0;  // receiver stall pattern enable

  always #5 clk_i = ~clk_i;

  // Clamp a raw extent to 1..256
  function automatic longint unsigned effective_extent(logic [CFG_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > 256) return 256;
    return raw;
  endfunction

  // Work out the neighbour of one site in the current configuration
  function automatic neighbor_res_t predict_neighbor(logic [SITE_W-1:0] site,
                                                     logic signed [DIR_W-1:0] dir);
    neighbor_res_t       r;
    longint unsigned     ext [4];
    longint unsigned     coord [4];
    longint unsigned     stride;
    longint unsigned     acc;
    int                  axis;
    bit                  fwd;
    stride = 1;
    r.bad = 1'b0;
    // Every 3-bit signed value maps to an axis when NUM_AXES is 4
    if (dir >= 0) begin
      axis = dir;
      fwd = 1'b1;
    end else begin
      axis = -int'(dir) - 1;
      fwd = 1'b0;
    end
    if (axis > 3) begin
      r.neighbor = site;
      r.bad = 1'b1;
      return r;
    end
    for (int k = 0; k < 4; k++) begin
      ext[k] = effective_extent(extent_raw[k]);
      coord[k] = (longint'(site) / stride) % ext[k];
      stride *= ext[k];
    end
    if (fwd) coord[axis] = (coord[axis] + 1) % ext[axis];
    else coord[axis] = (coord[axis] == 0) ? ext[axis] - 1 : coord[axis] - 1;
    acc = coord[3];
    for (int k = 3; k > 0; k--) acc = acc * ext[k-1] + coord[k-1];
    r.neighbor = acc[SITE_W-1:0];
    return r;
  endfunction

  // Cycle limit: fail on timeout
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: take up a long hold-off when asked, else stall on a pattern
  always @(posedge clk_i) begin
    if (hold_off_request != hold_off_granted) begin
      hold_off_granted <= hold_off_request;
      hold_off_cycles  <= HOLD_OFF_LEN - 1;
      out_ch.ready     <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ch.ready <= 1'b0;
    end else if (random_stalls) begin
      out_ch.ready <= ($urandom_range(0, 3) != 0);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Checker: compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin
    neighbor_res_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_neighbors.size() == 0) begin
        $display("%0t: unexpected result neighbor=%h bad=%b", $time,
                 out_ch.neighbor_index, out_ch.bad_direction);
        mismatch_count++;
      end else begin
        want = expected_neighbors.pop_front();
        if (want.neighbor !== out_ch.neighbor_index) begin
          $display("%0t: neighbor_index expected %h actual %h", $time,
                   want.neighbor, out_ch.neighbor_index);
          mismatch_count++;
        end
        if (want.bad !== out_ch.bad_direction) begin
          $display("%0t: bad_direction expected %b actual %b", $time,
                   want.bad, out_ch.bad_direction);
          mismatch_count++;
        end
      end
    end
  end

  // Write one register; update the predictor unless the index has no register
  task automatic write_extent(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx < NUM_REGS) extent_raw[idx[1:0]] = val;
  endtask

  task automatic set_extents(logic [CFG_W-1:0] x, logic [CFG_W-1:0] y,
                             logic [CFG_W-1:0] z, logic [CFG_W-1:0] t);
    write_extent(REG_EXTENT_X, x);
    write_extent(REG_EXTENT_Y, y);
    write_extent(REG_EXTENT_Z, z);
    write_extent(REG_EXTENT_T, t);
  endtask

  // Offer one transaction and hold it until accepted; valid stays high
  // into the next call, so back-to-back items never drop valid
  task automatic send_site(logic [SITE_W-1:0] site, logic signed [DIR_W-1:0] dir);
    in_ch.valid      <= 1'b1;
    in_ch.site_index <= site;
    in_ch.direction  <= dir;
    expected_neighbors.push_back(predict_neighbor(site, dir));
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic idle_sender(int cycles);
    in_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Wait until every expected result has come, then let the pipe settle
  task automatic drain_results();
    idle_sender(1);
    while (expected_neighbors.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  // Random site, biased towards the lattice volume and the field extremes
  function automatic logic [SITE_W-1:0] random_site();
    longint unsigned vol;
    vol = 1;
    for (int k = 0; k < 4; k++) vol *= effective_extent(extent_raw[k]);
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 3);
      2: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: return (vol > 32'hFFFF_FFFF) ? $urandom()
                                            : $urandom_range(0, int'(vol - 1));
    endcase
  endfunction

  // Send bursts of random items with random gaps between them
  task automatic random_traffic(int count);
    int sent;
    int burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 12);
      for (int i = 0; i < burst && sent < count; i++) begin
        send_site(random_site(), DIR_W'($urandom()));
        sent++;
      end
      if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 6));
    end
  endtask

  // Extremes of site and every direction, at the reset extents
  task automatic test_directed_extremes();
    for (int d = -4; d <= 3; d++) send_site(32'd0, DIR_W'(d));
    for (int d = -4; d <= 3; d++) send_site(32'hFFFF_FFFF, DIR_W'(d));
    send_site(32'd65535, 3'sd3);   // last site of 16^4 wraps on the slow axis
    send_site(32'd65536, -3'sd4);  // first index beyond the volume
    send_site(32'h5555_5555, 3'sd0);
    send_site(32'hAAAA_AAAA, -3'sd1);
    drain_results();
  endtask

  // Zero, oversized and out-of-range writes
  task automatic test_extent_clamping();
    set_extents(9'd0, 9'd511, 9'd257, 9'd256);
    write_extent(REG_NONE, 9'd3);  // dropped: no such register
    for (int d = -4; d <= 3; d++) send_site($urandom(), DIR_W'(d));
    drain_results();
    set_extents(9'd1, 9'd1, 9'd1, 9'd1);
    for (int d = -4; d <= 3; d++) send_site($urandom(), DIR_W'(d));
    drain_results();
  endtask

  task automatic test_random_configs();
    for (int phase = 0; phase < 6; phase++) begin
      set_extents(CFG_W'($urandom_range(0, 511)), CFG_W'($urandom_range(0, 20)),
                  CFG_W'($urandom_range(1, 256)), CFG_W'($urandom_range(0, 300)));
      random_traffic(32);
      drain_results();
    end
  endtask

  // Receiver holds off long while the sender keeps offering items
  task automatic test_backpressure();
    set_extents(9'd256, 9'd256, 9'd256, 9'd256);
    hold_off_request = hold_off_request + 1;
    random_traffic(180);
    drain_results();
  endtask

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.site_index = '0;
    in_ch.direction  = '0;
    for (int k = 0; k < 4; k++) extent_raw[k] = EXTENT_RESET;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_extremes();
    random_stalls = 1'b1;
    test_extent_clamping();
    test_random_configs();
    test_backpressure();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
